// ===== rtl/capp_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the pixel plot unit.
package capp_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;

    localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WD_W   = $clog2(MAX_WIDTH + 1);
    localparam int HT_W   = $clog2(MAX_HEIGHT + 1);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int CFG_W   = 9;
    localparam int COORD_W = 16;
    localparam int COLOR_W = 32;
    localparam int PADDR_W = 16;

    localparam int IN_DATA_W  = 2 * COORD_W + COLOR_W;
    localparam int OUT_DATA_W = PADDR_W + COLOR_W;

    localparam logic [CFG_W-1:0] CLIP_RESET = CFG_W'(256);

    // register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // request kinds
    localparam logic REQ_OPAQUE = 1'b0;
    localparam logic REQ_BLEND  = 1'b1;

    typedef struct packed {
        logic clear_step;
        logic load_req;
        logic do_clip;
        logic do_mix;
        logic commit;
    } capp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic in_area;
        logic blend;
    } capp_stat_t;

endpackage

// ===== rtl/clipped_alpha_pixel_plot_unit.sv =====
// Top level of the clipped pixel plot unit with source-over alpha blend.
//
//  Channel   Direction  Beat contents
//  s_*       in         tuser: req_type | tdata: pos_x, pos_y, src_color
//  m_*       out        tuser: written  | tdata: pixel_addr, pixel_value
//  cfg_*     in         index 0 frame width, index 1 frame height, 9-bit data
//
// After reset the frame store is swept to zero, one word a cycle, all 65536 words,
// with s_tready low. Register writes are taken during the sweep.
// Opaque or clipped request: the beat passes S_CLIP and S_ROUTE, then m_tvalid rises in S_OUT;
// a blend also passes S_MIX and S_DIV, set by the registered store read and the multiply and divide stages.
// One request is in flight at a time: the next beat is not taken until the result beat is;
// s_tready returns the cycle after the result beat is taken, so a stalled m_tready stalls input.
module clipped_alpha_pixel_plot_unit
    import capp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // pos_x[15:0], pos_y[31:16], src_color[63:32]
    input  logic                  s_tuser,   // req_type
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // pixel_addr[15:0], pixel_value[47:16]
    output logic                  m_tuser,   // written
    // register writes
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    capp_cmd_t  cmd;
    capp_stat_t stat;

    capp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    capp_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_type     (s_tuser),
        .in_data     (s_tdata),
        .out_written (m_tuser),
        .out_data    (m_tdata),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

// ===== rtl/capp_ctrl.sv =====
// Sequencing state machine for the pixel plot unit: clear pass, clip, read, mix, result.
module capp_ctrl
    import capp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output capp_cmd_t  cmd,
    input  capp_stat_t stat
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CLIP  = 3'd2;
    localparam logic [2:0] S_ROUTE = 3'd3;
    localparam logic [2:0] S_MIX   = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_CLIP;
                end
            end
            S_CLIP:
            begin
                cmd.do_clip = 1'b1;
                state_next  = S_ROUTE;
            end
            S_ROUTE:
            begin
                // old pixel read is under way this cycle
                if (stat.in_area && stat.blend)
                begin
                    state_next = S_MIX;
                end
                else
                begin
                    cmd.commit = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_MIX:
            begin
                cmd.do_mix = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.commit = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

`ifndef SYNTH
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !s_tready)
        else $error("input taken during clear pass");

    a_commit_then_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> m_tvalid)
        else $error("result not presented after commit");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input open while result pending");

    a_load_closes: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_req |=> !s_tready && !m_tvalid)
        else $error("request not held for processing");
`endif

endmodule

// ===== rtl/capp_datapath.sv =====
// Datapath: clip registers, address multiply, frame store, channel blend and result register.
module capp_datapath
    import capp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  in_type,
    input  logic [IN_DATA_W-1:0]  in_data,
    output logic                  out_written,
    output logic [OUT_DATA_W-1:0] out_data,
    input  capp_cmd_t             cmd,
    output capp_stat_t            stat
);

    logic [CFG_W-1:0]   width_cfg_reg;
    logic [CFG_W-1:0]   height_cfg_reg;
    logic [ADDR_W-1:0]  clr_cnt_reg;

    logic               type_reg;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic [COLOR_W-1:0] src_reg;

    logic               inside_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [COLOR_W-1:0] old_reg;
    logic [16:0]        sum_reg [3];

    logic               out_written_reg;
    logic [PADDR_W-1:0] out_addr_reg;
    logic [COLOR_W-1:0] out_value_reg;

    logic [COLOR_W-1:0] mem [DEPTH];

    logic [WD_W-1:0]      w_eff;
    logic [HT_W-1:0]      h_eff;
    logic                 inside_next;
    logic [WD_W+YW-1:0]   row_base;
    logic [ADDR_W-1:0]    addr_next;
    logic [7:0]           alpha;
    logic [7:0]           alpha_inv;
    logic [7:0]           quot [3];
    logic [17:0]          quot_sum [3];
    logic [COLOR_W-1:0]   mix_val;
    logic [COLOR_W-1:0]   new_val;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [COLOR_W-1:0]   mem_wdata;

    // configuration and clear sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= CLIP_RESET;
            height_cfg_reg <= CLIP_RESET;
            clr_cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_WIDTH)
            begin
                width_cfg_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_HEIGHT)
            begin
                height_cfg_reg <= cfg_data;
            end
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    // clamp to store geometry
    always_comb
    begin
        w_eff = (32'(width_cfg_reg) > 32'(MAX_WIDTH)) ? WD_W'(MAX_WIDTH)
                                                       : WD_W'(width_cfg_reg);
        h_eff = (32'(height_cfg_reg) > 32'(MAX_HEIGHT)) ? HT_W'(MAX_HEIGHT)
                                                         : HT_W'(height_cfg_reg);
        inside_next = !x_reg[COORD_W-1] && !y_reg[COORD_W-1]
                   && (32'(x_reg) < 32'(w_eff)) && (32'(y_reg) < 32'(h_eff));
        row_base  = w_eff * y_reg[YW-1:0];
        addr_next = ADDR_W'(x_reg[XW-1:0]) + ADDR_W'(row_base);
    end

    // blend: (v + (v >> 8) + 1) >> 8 equals v / 255 for v up to 255*255
    always_comb
    begin
        alpha     = src_reg[31:24];
        alpha_inv = ~alpha;
        for (int c = 0; c < 3; c++)
        begin
            quot_sum[c] = 18'(sum_reg[c]) + 18'(sum_reg[c][16:8]) + 18'd1;
            quot[c]     = quot_sum[c][15:8];
        end
        mix_val = {old_reg[31:24], quot[2], quot[1], quot[0]};
        new_val = (type_reg == REQ_BLEND) ? mix_val : src_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            type_reg <= in_type;
            x_reg    <= in_data[COORD_W-1:0];
            y_reg    <= in_data[2*COORD_W-1:COORD_W];
            src_reg  <= in_data[IN_DATA_W-1:2*COORD_W];
        end
        if (cmd.do_clip)
        begin
            inside_reg <= inside_next;
            addr_reg   <= addr_next;
        end
        if (cmd.do_mix)
        begin
            for (int c = 0; c < 3; c++)
            begin
                sum_reg[c] <= 17'(src_reg[8*c +: 8] * alpha)
                            + 17'(old_reg[8*c +: 8] * alpha_inv);
            end
        end
        if (cmd.commit)
        begin
            out_written_reg <= inside_reg;
            out_addr_reg    <= inside_reg ? PADDR_W'(addr_reg) : '0;
            out_value_reg   <= inside_reg ? new_val : '0;
        end
    end

    // frame store: one write port, one registered read port
    always_comb
    begin
        mem_we    = cmd.clear_step || (cmd.commit && inside_reg);
        mem_waddr = cmd.clear_step ? clr_cnt_reg : addr_reg;
        mem_wdata = cmd.clear_step ? '0 : new_val;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        old_reg <= mem[addr_reg];
    end

    assign stat.clear_last = (clr_cnt_reg == ADDR_W'(DEPTH - 1));
    assign stat.in_area    = inside_reg;
    assign stat.blend      = (type_reg == REQ_BLEND);

    assign out_written = out_written_reg;
    assign out_data    = {out_value_reg, out_addr_reg};

endmodule

// ===== tb/clipped_alpha_pixel_plot_unit_tb.sv =====
// Self-checking testbench for the clipped pixel plot unit with source-over alpha blend.
module clipped_alpha_pixel_plot_unit_tb
    import capp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Quiet-cycle limit: above the post-reset sweep, which holds s_tready low while all 65536
    // words are cleared, plus the longest receiver hold-off (LONG_HOLD).
    localparam int QUIET_LIMIT = 300000;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 8;     // pause after the last result is in

    typedef struct packed {
        logic                       req_type;
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_y;
        logic [COLOR_W-1:0]         src_color;
    } plot_req_t;

    typedef struct packed {
        logic                       written;
        logic [PADDR_W-1:0]         pixel_addr;
        logic [COLOR_W-1:0]         pixel_value;
    } plot_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;    // pos_x, pos_y, src_color
    logic                  s_tuser = 1'b0;  // req_type
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // pixel_addr, pixel_value
    logic                  m_tuser;         // written
    logic                  cfg_we = 1'b0;
    logic                  cfg_index = REG_WIDTH;
    logic [CFG_W-1:0]      cfg_data = '0;

    clipped_alpha_pixel_plot_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Mirror of the block: frame contents and the two clip registers.
    bit   [COLOR_W-1:0] frame_mem [DEPTH];
    logic [CFG_W-1:0]   clip_w = CLIP_RESET;
    logic [CFG_W-1:0]   clip_h = CLIP_RESET;

    plot_req_t    pending_reqs[$];   // beats waiting to be offered
    plot_result_t expected_px[$];    // predicted result beats, oldest first
    int           outstanding = 0;   // queued requests whose result is not yet in
    int           fail_count = 0;
    int           quiet_cycles = 0;
    logic         s_taken = 1'b0;

    int sender_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_requests = 0;
    int stall_served = 0;
    int hold_left = 0;

    logic signed [COORD_W-1:0] hot_x = '0;
    logic signed [COORD_W-1:0] hot_y = '0;

    // Register value as the block uses it: anything above the maximum acts as the maximum.
    function automatic int clamp_dim(logic [CFG_W-1:0] v, int cap);
        return (int'(v) > cap) ? cap : int'(v);
    endfunction

    function automatic logic [7:0] mix_byte(int s, int d, int a);
        return 8'((s * a + d * (255 - a)) / 255);
    endfunction

    // Predict the result of one request and update the mirrored frame.
    function automatic plot_result_t plot_pixel(plot_req_t r);
        plot_result_t       res;
        int                 wc;
        int                 hc;
        int                 x;
        int                 y;
        int                 addr;
        int                 a;
        logic [COLOR_W-1:0] old;
        logic [COLOR_W-1:0] val;
        res = '0;
        wc = clamp_dim(clip_w, MAX_WIDTH);
        hc = clamp_dim(clip_h, MAX_HEIGHT);
        x = r.pos_x;
        y = r.pos_y;
        if (x >= 0 && y >= 0 && x < wc && y < hc)
        begin
            addr = x + wc * y;
            if (r.req_type == REQ_OPAQUE)
                val = r.src_color;
            else
            begin
                // destination alpha byte survives a blend
                old = frame_mem[addr];
                a = r.src_color[31:24];
                val = {old[31:24],
                       mix_byte(r.src_color[23:16], old[23:16], a),
                       mix_byte(r.src_color[15:8],  old[15:8],  a),
                       mix_byte(r.src_color[7:0],   old[7:0],   a)};
            end
            frame_mem[addr] = val;
            res.written = 1'b1;
            res.pixel_addr = addr[PADDR_W-1:0];
            res.pixel_value = val;
        end
        return res;
    endfunction

    // Coordinates on and just past the clip edges, plus the field extremes.
    function automatic int edge_coord(int lim);
        case ($urandom_range(5))
            0: return -1;
            1: return 0;
            2: return lim - 1;
            3: return lim;
            4: return -32768;
            default: return 32767;
        endcase
    endfunction

    // Mostly in-area pixels, often revisiting the last one so that back-to-back
    // blends hit the same address; the rest edge cases and raw 16-bit noise.
    function automatic plot_req_t random_req(int wc, int hc);
        plot_req_t r;
        int        pick;
        r.req_type = $urandom_range(1) ? REQ_BLEND : REQ_OPAQUE;
        r.src_color = $urandom;
        case ($urandom_range(9))
            0: r.src_color[31:24] = 8'h00;
            1: r.src_color[31:24] = 8'hFF;
            default: ;
        endcase
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            r.pos_x = COORD_W'($urandom);
            r.pos_y = COORD_W'($urandom);
        end
        else if (pick < 22)
        begin
            r.pos_x = COORD_W'(edge_coord(wc));
            r.pos_y = COORD_W'(edge_coord(hc));
        end
        else if (pick < 40)
        begin
            r.pos_x = hot_x;
            r.pos_y = hot_y;
        end
        else if (wc > 0 && hc > 0)
        begin
            r.pos_x = COORD_W'($urandom_range(wc - 1));
            r.pos_y = COORD_W'($urandom_range(hc - 1));
        end
        else
        begin
            r.pos_x = COORD_W'($urandom_range(8));
            r.pos_y = COORD_W'($urandom_range(8));
        end
        hot_x = r.pos_x;
        hot_y = r.pos_y;
        return r;
    endfunction

    task automatic queue_req(logic kind, int x, int y, logic [COLOR_W-1:0] color);
        plot_req_t r;
        r.req_type = kind;
        r.pos_x = COORD_W'(x);
        r.pos_y = COORD_W'(y);
        r.src_color = color;
        pending_reqs.push_back(r);
        outstanding++;
    endtask

    // Sender holds back until every result is in, then lets the block settle.
    task automatic drain_block();
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_clip(logic idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_WIDTH)
            clip_w = val;
        else
            clip_h = val;
    endtask

    // Input side: a beat is held until taken, then the next one goes up,
    // unless the sender chooses to idle this cycle.
    always @(negedge clk)
    begin
        plot_req_t nxt;
        if (rst_n && (!s_tvalid || s_taken))
        begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                nxt = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= nxt.req_type;
                s_tdata <= {nxt.src_color, nxt.pos_y, nxt.pos_x};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result side: random back-pressure, or a long hold-off on request so that
    // the single request in flight blocks s_tready.
    always @(negedge clk)
    begin
        if (stall_served != stall_requests)
        begin
            stall_served = stall_requests;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: check result beats, predict from accepted input beats, watch for a hang.
    always @(posedge clk)
    begin
        plot_req_t    req;
        plot_result_t got;
        plot_result_t want;
        if (rst_n)
        begin
            s_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                got.written = m_tuser;
                got.pixel_addr = m_tdata[PADDR_W-1:0];
                got.pixel_value = m_tdata[PADDR_W +: COLOR_W];
                if (expected_px.size() == 0)
                begin
                    $error("result beat with nothing expected: written %0b addr %h value %h",
                           got.written, got.pixel_addr, got.pixel_value);
                    fail_count++;
                end
                else
                begin
                    want = expected_px.pop_front();
                    if (got.written !== want.written)
                    begin
                        $error("written: expected %0b, got %0b", want.written, got.written);
                        fail_count++;
                    end
                    if (got.pixel_addr !== want.pixel_addr)
                    begin
                        $error("pixel_addr: expected %h, got %h",
                               want.pixel_addr, got.pixel_addr);
                        fail_count++;
                    end
                    if (got.pixel_value !== want.pixel_value)
                    begin
                        $error("pixel_value: expected %h, got %h",
                               want.pixel_value, got.pixel_value);
                        fail_count++;
                    end
                end
                outstanding--;
            end
            if (s_tvalid && s_tready)
            begin
                req.req_type = s_tuser;
                req.pos_x = s_tdata[COORD_W-1:0];
                req.pos_y = s_tdata[COORD_W +: COORD_W];
                req.src_color = s_tdata[2*COORD_W +: COLOR_W];
                expected_px.push_back(plot_pixel(req));
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("clipped_alpha_pixel_plot_unit test failed");
                $finish;
            end
        end
    end

    // Random phases: clip setting, beat count, sender idle %, receiver idle %.
    int ph_w   [7] = '{300,   1,  17,   0, 256, 100, 256};
    int ph_h   [7] = '{511,   1, 200,   5,   0, 256, 256};
    int ph_n   [7] = '{250,  60, 250,  40,  40, 300, 360};
    int ph_sid [7] = '{  6,   6,  60,  60,  60,   0,   0};
    int ph_rid [7] = '{ 60,  60,   6,   6,   6,   0,   0};

    initial
    begin
        int wc;
        int hc;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // registers are taken during the clearing sweep
        write_clip(REG_WIDTH, 9'd256);
        write_clip(REG_HEIGHT, 9'd256);

        // Directed: corners, alpha extremes, blend onto a cleared pixel,
        // every side of the clip area and the coordinate extremes.
        sender_idle_pct = 6;
        recv_idle_pct = 60;
        queue_req(REQ_OPAQUE, 0, 0, 32'hFFFF_FFFF);
        queue_req(REQ_BLEND, 0, 0, 32'h0012_3456);     // zero alpha keeps destination
        queue_req(REQ_BLEND, 0, 0, 32'hFF12_3456);     // full alpha takes source colour
        queue_req(REQ_BLEND, 0, 0, 32'h8000_0000);
        queue_req(REQ_OPAQUE, 255, 255, 32'h80A0_B0C0);
        queue_req(REQ_BLEND, 255, 255, 32'h7F0F_1E2D);
        queue_req(REQ_BLEND, 10, 20, 32'hC0FF_FFFF);   // never written before
        queue_req(REQ_OPAQUE, 255, 0, 32'h0000_0000);
        queue_req(REQ_OPAQUE, 0, 255, 32'h5A5A_5A5A);
        queue_req(REQ_OPAQUE, -1, 0, 32'h1111_1111);
        queue_req(REQ_BLEND, 0, -1, 32'h2222_2222);
        queue_req(REQ_OPAQUE, 256, 0, 32'h3333_3333);
        queue_req(REQ_BLEND, 0, 256, 32'h4444_4444);
        queue_req(REQ_OPAQUE, -32768, -32768, 32'hFFFF_FFFF);
        queue_req(REQ_BLEND, 32767, 32767, 32'hFFFF_FFFF);
        queue_req(REQ_OPAQUE, -32768, 32767, 32'hA5A5_A5A5);
        queue_req(REQ_BLEND, 32767, -32768, 32'h5A5A_5A5A);
        queue_req(REQ_BLEND, 255, 255, 32'hFFFF_FFFF);
        queue_req(REQ_BLEND, 0, 0, 32'h01FF_FFFF);
        drain_block();

        for (int p = 0; p < 7; p++)
        begin
            write_clip(REG_WIDTH, CFG_W'(ph_w[p]));
            write_clip(REG_HEIGHT, CFG_W'(ph_h[p]));
            wc = clamp_dim(clip_w, MAX_WIDTH);
            hc = clamp_dim(clip_h, MAX_HEIGHT);
            sender_idle_pct = ph_sid[p];
            recv_idle_pct = ph_rid[p];
            for (int i = 0; i < ph_n[p]; i++)
            begin
                pending_reqs.push_back(random_req(wc, hc));
                outstanding++;
                // long receiver hold-off while the sender keeps offering beats
                if ((p == 0 || p == 5) && i == 20)
                    stall_requests++;
                // mid-phase pause until every result is back
                if (p == 2 && i == ph_n[p] / 2)
                    drain_block();
            end
            drain_block();
        end

        if (expected_px.size() != 0)
        begin
            $error("%0d expected result beats never arrived", expected_px.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("clipped_alpha_pixel_plot_unit test passed");
        else
            $display("clipped_alpha_pixel_plot_unit test failed");
        $finish;
    end

endmodule
